FILE: src/sfca_pkg.sv
// Shared types, codes and CRC helpers for the sensor frame check and accumulate block.
`timescale 1ns / 1ps

package sfca_pkg;

  // Default widths of the internal accumulators
  localparam int SFCA_COUNT_BITS = 24;
  localparam int SFCA_SUM_BITS   = 48;

  // Fixed widths of the reported fields
  localparam int SFCA_SUM_OUT_W   = 48;
  localparam int SFCA_COUNT_OUT_W = 24;

  // Operation codes
  localparam logic OP_FRAME    = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  // Slot codes
  localparam logic [2:0] SLOT_DISCARD = 3'd0;
  localparam logic [2:0] SLOT_X       = 3'd1;
  localparam logic [2:0] SLOT_Y       = 3'd2;
  localparam logic [2:0] SLOT_Z       = 3'd3;
  localparam logic [2:0] SLOT_TILT    = 3'd4;
  localparam logic [2:0] SLOT_TEMP    = 3'd5;

  // Round valid bit positions
  localparam int VBIT_X    = 0;
  localparam int VBIT_Y    = 1;
  localparam int VBIT_Z    = 2;
  localparam int VBIT_TILT = 3;

  // CRC-8 constants
  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Tilt value before any valid tilt word: -100
  localparam logic [15:0] TILT_RESET = 16'hFF9C;

  typedef struct packed {
    logic        operation;
    logic [31:0] frame_word;
    logic [2:0]  slot;
  } sfca_req_t;

  typedef struct packed {
    logic                 crc_ok;
    logic [4:0]           reg_addr;
    logic [1:0]           return_status;
    logic signed [15:0]   payload;
    logic signed [47:0]   sum_x;
    logic signed [47:0]   sum_y;
    logic signed [47:0]   sum_z;
    logic signed [47:0]   sum_temperature;
    logic [23:0]          sample_count;
    logic signed [15:0]   last_tilt;
    logic [31:0]          frames_seen;
    logic [31:0]          frames_good;
  } sfca_rsp_t;

  // Decoded frame fields handed from the decoder to the top level
  typedef struct packed {
    logic               crc_ok;
    logic [4:0]         reg_addr;
    logic [1:0]         return_status;
    logic signed [15:0] payload;
  } sfca_info_t;

  // Bit-serial CRC-8, MSB first; used only to build constants at elaboration
  function automatic logic [7:0] crc8_serial(input logic [23:0] data, input logic [7:0] init);
    logic [7:0] c;
    logic       fb;
    c = init;
    for (int b = 23; b >= 0; b--) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Contribution of each data bit to the CRC register (zero init)
  function automatic logic [23:0][7:0] crc8_columns();
    logic [23:0][7:0] cols;
    for (int j = 0; j < 24; j++) begin
      cols[j] = crc8_serial(24'd1 << j, 8'h00);
    end
    return cols;
  endfunction

endpackage

FILE: src/sfca_frame_decode.sv
// Frame decoder: parallel CRC-8 check and field split of one response frame.
`timescale 1ns / 1ps

module sfca_frame_decode (
  input  logic [31:0]         frame_word,
  output sfca_pkg::sfca_info_t info
);
  import sfca_pkg::*;

  // CRC is linear: fixed init term plus one column per set data bit
  localparam logic [23:0][7:0] CRC_COLS = crc8_columns();
  localparam logic [7:0]       CRC_BASE = crc8_serial(24'd0, CRC_INIT);

  logic [7:0] crc_reg;

  // XOR of independent column terms
  always_comb begin
    crc_reg = CRC_BASE;
    for (int j = 0; j < 24; j++) begin
      if (frame_word[8 + j]) begin
        crc_reg = crc_reg ^ CRC_COLS[j];
      end
    end
  end

  // Field split
  assign info.crc_ok        = (~crc_reg) == frame_word[7:0];
  assign info.reg_addr      = frame_word[30:26];
  assign info.return_status = frame_word[25:24];
  assign info.payload       = frame_word[23:8];

endmodule

FILE: src/sensor_frame_check_accumulate.sv
// Top level: frame register, round accumulation and registered result.
// A request accepted into the input register moves on to the result register once that register is free.
// Throughput: one request per cycle while the result is not stalled; the input register and the result register
// form a two-entry pipeline, so a request is taken while a result waits.
// All work for a request is one pass of CRC, compare and add between those registers.
// Reset (rst, synchronous): sums, count and counters clear, tilt goes to -100.
`timescale 1ns / 1ps

module sensor_frame_check_accumulate #(
  parameter int COUNT_BITS = sfca_pkg::SFCA_COUNT_BITS,
  parameter int SUM_BITS   = sfca_pkg::SFCA_SUM_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  sfca_pkg::sfca_req_t frame,
  output logic                result_valid,
  input  logic                result_stall,
  output sfca_pkg::sfca_rsp_t result
);
  import sfca_pkg::*;

  // Pipeline control
  logic      s1_valid;
  sfca_req_t s1;
  logic      frame_take;
  logic      result_take;
  logic      result_free;
  logic      s1_move;

  // Block state
  logic [SUM_BITS-1:0]   acc_x;
  logic [SUM_BITS-1:0]   acc_y;
  logic [SUM_BITS-1:0]   acc_z;
  logic [SUM_BITS-1:0]   acc_temp;
  logic [COUNT_BITS-1:0] round_count;
  logic [15:0]           tilt_hold;
  logic [15:0]           round_values [4];
  logic [3:0]            round_valid;
  logic [31:0]           frame_total;
  logic [31:0]           frame_ok_total;

  logic [SUM_BITS-1:0]   acc_x_next;
  logic [SUM_BITS-1:0]   acc_y_next;
  logic [SUM_BITS-1:0]   acc_z_next;
  logic [SUM_BITS-1:0]   acc_temp_next;
  logic [COUNT_BITS-1:0] round_count_next;
  logic [15:0]           tilt_hold_next;
  logic [15:0]           round_values_next [4];
  logic [3:0]            round_valid_next;
  logic [31:0]           frame_total_next;
  logic [31:0]           frame_ok_total_next;

  sfca_info_t    info;
  sfca_rsp_t     result_next;
  logic          hit;
  logic          commit;
  logic [1:0]    slot_idx;
  logic [63:0]   wide_x;
  logic [63:0]   wide_y;
  logic [63:0]   wide_z;
  logic [63:0]   wide_temp;
  logic [31:0]   wide_count;

  // Handshake
  assign result_take = result_valid && !result_stall;
  assign result_free = !result_valid || result_take;
  assign s1_move     = s1_valid && result_free;
  assign frame_stall = s1_valid && !result_free;
  assign frame_take  = frame_valid && !frame_stall;

  sfca_frame_decode u_decode (
    .frame_word (s1.frame_word),
    .info       (info)
  );

  assign hit      = info.crc_ok && (info.reg_addr == {2'b00, s1.slot});
  assign slot_idx = 2'(s1.slot - SLOT_X);
  assign commit   = hit && (round_valid[VBIT_Z:VBIT_X] == 3'b111) && !(&round_count);

  // Next state and result for the request in the input register
  always_comb begin
    acc_x_next          = acc_x;
    acc_y_next          = acc_y;
    acc_z_next          = acc_z;
    acc_temp_next       = acc_temp;
    round_count_next    = round_count;
    tilt_hold_next      = tilt_hold;
    round_values_next   = round_values;
    round_valid_next    = round_valid;
    frame_total_next    = frame_total;
    frame_ok_total_next = frame_ok_total;

    if (s1.operation == OP_FRAME) begin
      frame_total_next = frame_total + 32'd1;
      if (info.crc_ok) begin
        frame_ok_total_next = frame_ok_total + 32'd1;
      end
      unique case (s1.slot) inside
        SLOT_X, SLOT_Y, SLOT_Z, SLOT_TILT: begin
          round_values_next[slot_idx] = info.payload;
          round_valid_next[slot_idx]  = hit;
        end
        SLOT_TEMP: begin
          if (commit) begin
            acc_x_next       = acc_x + {{(SUM_BITS-16){round_values[0][15]}}, round_values[0]};
            acc_y_next       = acc_y + {{(SUM_BITS-16){round_values[1][15]}}, round_values[1]};
            acc_z_next       = acc_z + {{(SUM_BITS-16){round_values[2][15]}}, round_values[2]};
            acc_temp_next    = acc_temp + {{(SUM_BITS-16){info.payload[15]}}, info.payload};
            round_count_next = round_count + COUNT_BITS'(1);
            if (round_valid[VBIT_TILT]) begin
              tilt_hold_next = round_values[3];
            end
          end
          round_valid_next = '0;
        end
        default: begin
        end
      endcase
    end

    // Reported sums: after this frame, or before the clear for a snapshot
    wide_x     = 64'(acc_x_next);
    wide_y     = 64'(acc_y_next);
    wide_z     = 64'(acc_z_next);
    wide_temp  = 64'(acc_temp_next);
    wide_count = 32'(round_count_next);

    result_next.sum_x           = wide_x[SFCA_SUM_OUT_W-1:0];
    result_next.sum_y           = wide_y[SFCA_SUM_OUT_W-1:0];
    result_next.sum_z           = wide_z[SFCA_SUM_OUT_W-1:0];
    result_next.sum_temperature = wide_temp[SFCA_SUM_OUT_W-1:0];
    result_next.sample_count    = wide_count[SFCA_COUNT_OUT_W-1:0];
    result_next.last_tilt       = tilt_hold_next;
    result_next.frames_seen     = frame_total_next;
    result_next.frames_good     = frame_ok_total_next;

    if (s1.operation == OP_SNAPSHOT) begin
      result_next.crc_ok        = 1'b0;
      result_next.reg_addr      = '0;
      result_next.return_status = '0;
      result_next.payload       = '0;
      acc_x_next                = '0;
      acc_y_next                = '0;
      acc_z_next                = '0;
      acc_temp_next             = '0;
      round_count_next          = '0;
    end else begin
      result_next.crc_ok        = info.crc_ok;
      result_next.reg_addr      = info.reg_addr;
      result_next.return_status = info.return_status;
      result_next.payload       = info.payload;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (frame_take) begin
      s1 <= frame;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
    if (s1_move) begin
      result <= result_next;
    end
  end

  // Block state update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x          <= '0;
      acc_y          <= '0;
      acc_z          <= '0;
      acc_temp       <= '0;
      round_count    <= '0;
      tilt_hold      <= TILT_RESET;
      round_values   <= '{default: '0};
      round_valid    <= '0;
      frame_total    <= '0;
      frame_ok_total <= '0;
    end else if (s1_move) begin
      acc_x          <= acc_x_next;
      acc_y          <= acc_y_next;
      acc_z          <= acc_z_next;
      acc_temp       <= acc_temp_next;
      round_count    <= round_count_next;
      tilt_hold      <= tilt_hold_next;
      round_values   <= round_values_next;
      round_valid    <= round_valid_next;
      frame_total    <= frame_total_next;
      frame_ok_total <= frame_ok_total_next;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (s1_valid && result_valid && result_stall))
    else $error("stall raised while pipeline has room");

  a_snapshot_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1.operation == OP_SNAPSHOT) |=> (acc_x == '0 && round_count == '0))
    else $error("snapshot did not clear sums and count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1.operation == OP_FRAME) |=> (round_count >= $past(round_count)))
    else $error("round count went down on a frame");

  a_frame_counted: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1.operation == OP_FRAME) |=> (frame_total == $past(frame_total) + 32'd1))
    else $error("frame counter did not advance");

endmodule
